// File: sv/mei_pkg.sv
package mei_pkg;

    // processor event kinds carried on s_tuser
    typedef enum logic [2:0] {
        EV_IO         = 3'd0,
        EV_INT_ACK    = 3'd1,
        EV_JUMP       = 3'd2,
        EV_MEM_READ   = 3'd3,
        EV_PERM_CHECK = 3'd4
    } mei_event_t;

    localparam int WORD_W     = 12;
    localparam int FIELD_W    = 3;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 32;

    // I/O words handled here
    localparam logic [WORD_W-1:0] IOT_FIELD_MASK = 12'o7707;
    localparam logic [WORD_W-1:0] IOT_CDF        = 12'o6201;
    localparam logic [WORD_W-1:0] IOT_CIF        = 12'o6202;
    localparam logic [WORD_W-1:0] IOT_CDI        = 12'o6203;
    localparam logic [WORD_W-1:0] IOT_SKON       = 12'o6000;
    localparam logic [WORD_W-1:0] IOT_ION        = 12'o6001;
    localparam logic [WORD_W-1:0] IOT_IOF        = 12'o6002;
    localparam logic [WORD_W-1:0] IOT_SRQ        = 12'o6003;
    localparam logic [WORD_W-1:0] IOT_GTF        = 12'o6004;
    localparam logic [WORD_W-1:0] IOT_RTF        = 12'o6005;
    localparam logic [WORD_W-1:0] IOT_SGT        = 12'o6006;
    localparam logic [WORD_W-1:0] IOT_CAF        = 12'o6007;
    localparam logic [WORD_W-1:0] IOT_RDF        = 12'o6214;
    localparam logic [WORD_W-1:0] IOT_RIF        = 12'o6224;
    localparam logic [WORD_W-1:0] IOT_RIB        = 12'o6234;
    localparam logic [WORD_W-1:0] IOT_RMF        = 12'o6244;
    localparam logic [WORD_W-1:0] IOT_CINT       = 12'o6204;
    localparam logic [WORD_W-1:0] IOT_SINT       = 12'o6254;
    localparam logic [WORD_W-1:0] IOT_CUF        = 12'o6264;
    localparam logic [WORD_W-1:0] IOT_SUF        = 12'o6274;

    // top two bits of a jump or jms instruction word
    localparam logic [1:0] JMP_CLASS = 2'b10;

    typedef struct packed {
        logic [FIELD_W-1:0] cur_instr_field;
        logic [FIELD_W-1:0] next_instr_field;
        logic [FIELD_W-1:0] cur_data_field;
        logic [FIELD_W-1:0] saved_instr_field;
        logic [FIELD_W-1:0] saved_data_field;
        logic               saved_user;
        logic               cur_user;
        logic               next_user;
        logic               int_enable;
        logic               int_enable_after_fetch;
        logic               int_blocked_until_jump;
    } mei_state_t;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [WORD_W-1:0] io_instruction;
        logic              link_in;
        logic [WORD_W-1:0] ac_in;
        logic [WORD_W-1:0] read_data;
        logic              in_fetch2;
        logic              irq_pending;
        logic              user_irq_pending;
        logic              gt_flag_in;
    } mei_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] data_field;
        logic [FIELD_W-1:0] instr_field;
        logic               user_mode;
        logic               interrupts_enabled;
        logic               gt_value;
        logic               gt_write;
        logic               clear_user_irq;
        logic               set_user_irq;
        logic               unsupported;
        logic               skip;
        logic [WORD_W-1:0]  ac_out;
        logic               link_out;
    } mei_result_t;

endpackage

// File: sv/mei_decode.sv
module mei_decode (
    input  mei_pkg::mei_item_t   item,
    input  mei_pkg::mei_state_t  st,
    output mei_pkg::mei_state_t  st_next,
    output mei_pkg::mei_result_t res
);
    import mei_pkg::*;

    logic [FIELD_W-1:0] field;
    logic [WORD_W-1:0]  lo;

    assign field = item.io_instruction[5:3];
    assign lo    = item.io_instruction & IOT_FIELD_MASK;

    always_comb begin
        st_next = st;
        res = '0;
        res.link_out = item.link_in;
        res.ac_out   = item.ac_in;
        unique case (item.opcode)
            EV_IO: begin
                if (lo == IOT_CDF) begin
                    st_next.cur_data_field = field;
                end else if (lo == IOT_CIF || lo == IOT_CDI) begin
                    if (lo == IOT_CDI) begin
                        st_next.cur_data_field = field;
                    end
                    st_next.next_instr_field       = field;
                    st_next.int_blocked_until_jump = 1'b1;
                end else begin
                    unique case (item.io_instruction)
                        IOT_SKON: begin
                            res.skip = st.int_enable;
                            st_next.int_enable             = 1'b0;
                            st_next.int_enable_after_fetch = 1'b0;
                        end
                        IOT_ION: st_next.int_enable_after_fetch = 1'b1;
                        IOT_IOF: begin
                            st_next.int_enable             = 1'b0;
                            st_next.int_enable_after_fetch = 1'b0;
                        end
                        IOT_SRQ: res.skip = item.irq_pending;
                        IOT_GTF: begin
                            // no-interrupt bit 8 reads as zero
                            res.ac_out = {item.link_in, item.gt_flag_in, item.irq_pending,
                                          1'b0, st.int_enable, st.saved_user,
                                          st.saved_instr_field, st.saved_data_field};
                        end
                        IOT_RTF: begin
                            res.link_out = item.ac_in[11];
                            res.gt_write = 1'b1;
                            res.gt_value = item.ac_in[10];
                            st_next.int_blocked_until_jump = 1'b1;
                            st_next.int_enable_after_fetch = 1'b1;
                            st_next.next_user        = item.ac_in[6];
                            st_next.next_instr_field = item.ac_in[5:3];
                            st_next.cur_data_field   = item.ac_in[2:0];
                        end
                        IOT_SGT: res.skip = item.gt_flag_in;
                        IOT_CAF: begin
                            st_next.cur_instr_field        = '0;
                            st_next.cur_data_field         = '0;
                            st_next.cur_user               = 1'b0;
                            st_next.int_enable             = 1'b0;
                            st_next.int_enable_after_fetch = 1'b0;
                            st_next.int_blocked_until_jump = 1'b0;
                            res.clear_user_irq = 1'b1;
                            res.link_out       = 1'b0;
                            res.ac_out         = '0;
                        end
                        IOT_RDF: res.ac_out = item.ac_in | {6'b0, st.cur_data_field, 3'b0};
                        IOT_RIF: res.ac_out = item.ac_in | {6'b0, st.cur_instr_field, 3'b0};
                        IOT_RIB: res.ac_out = item.ac_in | {5'b0, st.saved_user,
                                                            st.saved_instr_field,
                                                            st.saved_data_field};
                        IOT_RMF: begin
                            st_next.cur_data_field   = st.saved_data_field;
                            st_next.next_instr_field = st.saved_instr_field;
                            st_next.next_user        = st.saved_user;
                        end
                        IOT_CINT: res.clear_user_irq = 1'b1;
                        IOT_SINT: res.skip = item.user_irq_pending;
                        IOT_CUF: begin
                            st_next.cur_user  = 1'b0;
                            st_next.next_user = 1'b0;
                        end
                        IOT_SUF: begin
                            st_next.next_user              = 1'b1;
                            st_next.int_blocked_until_jump = 1'b1;
                        end
                        default: res.unsupported = 1'b1;
                    endcase
                end
            end
            EV_INT_ACK: begin
                st_next.saved_instr_field      = st.cur_instr_field;
                st_next.saved_data_field       = st.cur_data_field;
                st_next.saved_user             = st.cur_user;
                st_next.int_enable             = 1'b0;
                st_next.int_enable_after_fetch = 1'b0;
                st_next.cur_instr_field        = '0;
                st_next.next_instr_field       = '0;
                st_next.cur_data_field         = '0;
                st_next.cur_user               = 1'b0;
                st_next.next_user              = 1'b0;
            end
            EV_JUMP: begin
                st_next.cur_instr_field        = st.next_instr_field;
                st_next.cur_user               = st.next_user;
                st_next.int_blocked_until_jump = 1'b0;
            end
            EV_MEM_READ: begin
                st_next.int_enable = st.int_enable_after_fetch;
                if (item.in_fetch2 && item.read_data[11:10] == JMP_CLASS) begin
                    st_next.int_blocked_until_jump = 1'b0;
                end
            end
            EV_PERM_CHECK: res.set_user_irq = st.cur_user;
            default: ;
        endcase
        res.interrupts_enabled = st_next.int_enable & ~st_next.int_blocked_until_jump;
        res.user_mode   = st_next.cur_user;
        res.instr_field = st_next.cur_instr_field;
        res.data_field  = st_next.cur_data_field;
    end

endmodule

// File: sv/mei_state.sv
module mei_state (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                update,
    input  mei_pkg::mei_state_t st_next,
    output mei_pkg::mei_state_t st
);
    import mei_pkg::*;

    mei_state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (update) begin
            state_reg <= st_next;
        end
    end

    assign st = state_reg;

endmodule

// File: sv/memory_extension_interrupt_control.sv
// memory-extension and interrupt-control unit for a 12-bit minicomputer. each
// input transfer is one processor event (kind on s_tuser: io instruction,
// interrupt ack, jump, memory read, io permission check) and gives exactly one
// result transfer with the new link/ac, the skip, unsupported, user-fault and
// greater-than strobes, and the instruction field, data field, user mode and
// interrupt-enable status in effect after the event. one transfer is taken
// every cycle unless m_tready low holds a full result register; the input
// register then keeps its event and s_tready drops. an event passes an input
// register, one level of decode and a result register before it is presented
// on m_tdata. the unit state is updated as an event leaves the
// input register, so events act strictly in arrival order. clear-all-flags
// (6007) clears this unit's current fields, user mode, interrupt flags, ac and link.
module memory_extension_interrupt_control (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // io_instruction[11:0], link_in[12], ac_in[24:13], read_data[36:25],
    // in_fetch2[37], irq_pending[38], user_irq_pending[39], gt_flag_in[40]
    input  logic [mei_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  logic [mei_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // link_out[0], ac_out[12:1], skip[13], unsupported[14], set_user_irq[15],
    // clear_user_irq[16], gt_write[17], gt_value[18], interrupts_enabled[19],
    // user_mode[20], instr_field[23:21], data_field[26:24]
    output logic [mei_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mei_pkg::*;

    localparam int RES_W = $bits(mei_result_t);

    // input register stage
    logic        in_valid_reg;
    mei_item_t   in_item_reg;
    // result register stage
    logic        out_valid_reg;
    mei_result_t out_res_reg;

    mei_item_t   s_item;
    mei_state_t  st;
    mei_state_t  st_next;
    mei_result_t res;
    logic        out_load;
    logic        s_xfer;

    // unpack the input transfer
    assign s_item.opcode           = s_tuser;
    assign s_item.io_instruction   = s_tdata[11:0];
    assign s_item.link_in          = s_tdata[12];
    assign s_item.ac_in            = s_tdata[24:13];
    assign s_item.read_data        = s_tdata[36:25];
    assign s_item.in_fetch2        = s_tdata[37];
    assign s_item.irq_pending      = s_tdata[38];
    assign s_item.user_irq_pending = s_tdata[39];
    assign s_item.gt_flag_in       = s_tdata[40];

    // the result register takes a new event when empty or being drained
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    // the input register frees up in the same cycle it hands off
    assign s_tready = !in_valid_reg || out_load;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_res_reg <= res;
        end
    end

    mei_decode u_decode (
        .item    (in_item_reg),
        .st      (st),
        .st_next (st_next),
        .res     (res)
    );

    // state moves together with the event into the result register
    mei_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (out_load),
        .st_next (st_next),
        .st      (st)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_res_reg};

    // an event waiting on a stalled result register keeps its slot
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_load) |=> in_valid_reg)
        else $error("input stage lost an event while stalled");

    // state only changes when an event is handed to the result register
    a_state_still: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> $stable(st))
        else $error("unit state changed with no event moving");

    // reported fields match the state left behind by the event
    a_fields_match: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (out_res_reg.user_mode == st.cur_user
                      && out_res_reg.instr_field == st.cur_instr_field
                      && out_res_reg.data_field == st.cur_data_field))
        else $error("result fields disagree with unit state");

    // clear-all-flags leaves zero fields and interrupts off
    a_caf_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && in_item_reg.opcode == EV_IO && in_item_reg.io_instruction == IOT_CAF)
        |=> (st.cur_instr_field == '0 && st.cur_data_field == '0
             && !st.int_enable && !out_res_reg.interrupts_enabled))
        else $error("clear-all-flags did not clear the unit");

    // a full result register that is not taken keeps its valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("result dropped while stalled");

endmodule
